[rtl/core/ppe_pkg.sv]
package ppe_pkg;

  localparam int MaxTracks       = 32;
  localparam int MaxEffects      = 4;
  localparam int MaxPatternBytes = 65536;

  localparam logic [1:0] KIND_NOTE   = 2'd0;
  localparam logic [1:0] KIND_EFFECT = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_TOO_MANY  = 2'd2;

  localparam logic [0:0] REG_BASE_CHANNELS = 1'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [16:0] row;
    logic [5:0] channel;
    logic [7:0] note;
    logic [7:0] sample;
    logic [7:0] fx_byte;
    logic [7:0] param;
    logic [1:0] status;
  } ppe_evt_t;

  function automatic logic [5:0] ppe_classify(input logic [4:0] fx, input logic [7:0] prm);
    logic [3:0] hi;
    logic [5:0] r;
    hi = prm[7:4];
    if (fx == 5'd0) r = 6'd0;
    else if (fx <= 5'd13) r = {1'b0, fx} + 6'd1;
    else if (fx == 5'd14) begin
      unique case (hi)
        4'h0: r = 6'd15;
        4'h1, 4'h2: r = 6'd16;
        4'h3: r = 6'd17;
        4'h4: r = 6'd18;
        4'h5: r = 6'd19;
        4'h6: r = 6'd20;
        4'h7: r = 6'd21;
        4'h8, 4'h9: r = 6'd22;
        4'ha, 4'hb: r = 6'd23;
        4'hc: r = 6'd24;
        4'hd: r = 6'd25;
        4'he: r = 6'd26;
        default: r = 6'd27;
      endcase
    end else if (fx <= 5'd20) r = {1'b0, fx} + 6'd13;
    else if (fx == 5'h1e) begin
      if (hi == 4'h0) r = 6'd34;
      else if (hi == 4'h8) r = 6'd35;
      else if (hi == 4'hd) r = 6'd36;
      else r = 6'd37;
    end else if (fx == 5'h1f) r = 6'd38;
    else r = 6'd1;
    return r;
  endfunction

endpackage

[rtl/core/ppe_front.sv]
module ppe_front import ppe_pkg::*; #(
  parameter int MAX_TRACKS        = MaxTracks,
  parameter int MAX_EFFECTS       = MaxEffects,
  parameter int MAX_PATTERN_BYTES = MaxPatternBytes
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_mode,
  input  logic [7:0]     in_data,
  input  logic [5:0]     base_channels,
  output logic           q_push,
  output ppe_evt_t       q_evt,
  input  logic           q_full
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_NOTE, PH_SAMPLE, PH_FXBYTE, PH_FXPARAM, PH_DRAIN
  } phase_t;

  phase_t      phase_r;
  logic [1:0]  flags_r;
  logic [4:0]  track_r;
  logic [7:0]  note_r;
  logic [7:0]  fxb_r;
  logic [2:0]  fxcnt_r;
  logic [16:0] row_r;
  logic [5:0]  maxch_r;
  logic [1:0]  err_r;
  logic        rowend_r;

  logic        acc;
  logic [16:0] rows;
  logic [5:0]  ch;
  logic [1:0]  st;

  assign in_stall = q_full;
  assign acc = in_valid && !in_stall;

  always_comb begin
    rows = row_r;
    if (!rowend_r && row_r < 17'(MAX_PATTERN_BYTES)) rows = row_r + 17'd1;
    if (rows == 17'd0) rows = 17'd1;
    ch = (base_channels > maxch_r) ? base_channels : maxch_r;
    if (ch == 6'd0) ch = 6'd1;
    if (ch > 6'(MAX_TRACKS)) ch = 6'(MAX_TRACKS);
    st = err_r;
    if (st == ST_OK && phase_r != PH_LEAD) st = ST_TRUNCATED;
  end

  always_comb begin
    q_push = 1'b0;
    q_evt = '0;
    q_evt.row = row_r;
    q_evt.channel = {1'b0, track_r};
    if (acc) begin
      if (in_mode) begin
        q_push = 1'b1;
        q_evt.kind = KIND_END;
        q_evt.row = rows;
        q_evt.channel = ch;
        q_evt.status = st;
      end else if (phase_r == PH_SAMPLE) begin
        q_push = 1'b1;
        q_evt.kind = KIND_NOTE;
        q_evt.note = note_r;
        q_evt.sample = in_data;
      end else if (phase_r == PH_FXPARAM) begin
        q_push = 1'b1;
        q_evt.kind = KIND_EFFECT;
        q_evt.fx_byte = fxb_r;
        q_evt.param = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_mode)) begin
      phase_r <= PH_LEAD;
      flags_r <= '0;
      track_r <= '0;
      note_r <= '0;
      fxb_r <= '0;
      fxcnt_r <= '0;
      row_r <= '0;
      maxch_r <= '0;
      err_r <= ST_OK;
      rowend_r <= 1'b0;
    end else if (acc) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (in_data == 8'd0) begin
            if (row_r < 17'(MAX_PATTERN_BYTES)) row_r <= row_r + 17'd1;
            rowend_r <= 1'b1;
          end else begin
            rowend_r <= 1'b0;
            track_r <= in_data[4:0];
            if ({1'b0, in_data[4:0]} + 6'd1 > maxch_r) maxch_r <= {1'b0, in_data[4:0]} + 6'd1;
            flags_r <= in_data[6:5];
            fxcnt_r <= '0;
            if (in_data[5]) phase_r <= PH_NOTE;
            else if (in_data[6]) phase_r <= PH_FXBYTE;
          end
        end
        PH_NOTE: begin
          note_r <= in_data;
          phase_r <= PH_SAMPLE;
        end
        PH_SAMPLE: phase_r <= flags_r[1] ? PH_FXBYTE : PH_LEAD;
        PH_FXBYTE: begin
          fxb_r <= in_data;
          phase_r <= PH_FXPARAM;
        end
        PH_FXPARAM: begin
          if (fxb_r[5]) begin
            fxcnt_r <= fxcnt_r + 3'd1;
            if (fxcnt_r + 3'd1 >= 3'(MAX_EFFECTS)) begin
              err_r <= ST_TOO_MANY;
              phase_r <= PH_DRAIN;
            end else begin
              phase_r <= PH_FXBYTE;
            end
          end else begin
            phase_r <= PH_LEAD;
          end
        end
        default: phase_r <= PH_DRAIN;
      endcase
    end
  end

  a_drain_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DRAIN |-> err_r == ST_TOO_MANY) else $error("drain without error");
  a_push_acc: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> acc) else $error("push without accept");
  a_fxcnt: assert property (@(posedge clk) disable iff (!rst_n)
    fxcnt_r <= 3'(MAX_EFFECTS)) else $error("effect count overflow");

endmodule

[rtl/core/ppe_back.sv]
module ppe_back import ppe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_push,
  input  ppe_evt_t    q_evt,
  output logic        q_full,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [16:0] out_row,
  output logic [5:0]  out_channel,
  output logic [7:0]  out_note,
  output logic [7:0]  out_sample,
  output logic [1:0]  out_effect_slot,
  output logic [4:0]  out_effect,
  output logic [7:0]  out_param,
  output logic [5:0]  out_effect_class,
  output logic [1:0]  out_status
);

  ppe_evt_t   slot_r [2];
  logic [1:0] vld_r;
  logic       pop;
  ppe_evt_t   h;

  assign h = slot_r[0];
  assign out_valid = vld_r[0];
  assign pop = vld_r[0] && !out_stall;
  assign q_full = vld_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      priority case ({q_push, pop})
        2'b10: vld_r <= vld_r[0] ? 2'b11 : 2'b01;
        2'b01: vld_r <= vld_r[1] ? 2'b01 : 2'b00;
        default: vld_r <= vld_r;
      endcase
    end
    if (pop) begin
      slot_r[0] <= vld_r[1] ? slot_r[1] : q_evt;
      if (vld_r[1]) slot_r[1] <= q_evt;
    end else if (q_push) begin
      if (vld_r[0]) slot_r[1] <= q_evt;
      else slot_r[0] <= q_evt;
    end
  end

  assign out_kind = h.kind;
  assign out_row = h.row;
  assign out_channel = h.channel;
  assign out_note = h.note;
  assign out_sample = h.sample;
  assign out_status = h.status;
  assign out_effect_slot = (h.kind == KIND_EFFECT) ? h.fx_byte[7:6] : 2'd0;
  assign out_effect = (h.kind == KIND_EFFECT) ? h.fx_byte[4:0] : 5'd0;
  assign out_param = h.param;
  assign out_effect_class = (h.kind == KIND_EFFECT) ? ppe_classify(h.fx_byte[4:0], h.param) : 6'd0;

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> vld_r[0]) else $error("queue hole");
  a_noovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !pop |-> !q_push) else $error("queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)) else $error("output dropped");

endmodule

[rtl/core/packed_pattern_event_decoder.sv]
// Decodes a packed tracker pattern one byte per clock cycle, one transaction per cycle
// sustained while in_stall is low. A front parser classifies each byte and a two-entry
// queue feeds the output side, so input is stalled only when two results wait; an end
// transaction emits the row count, channel count and status and restarts the parser.
module packed_pattern_event_decoder import ppe_pkg::*; #(
  parameter int MAX_TRACKS        = MaxTracks,
  parameter int MAX_EFFECTS       = MaxEffects,
  parameter int MAX_PATTERN_BYTES = MaxPatternBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [16:0] out_row,
  output logic [5:0]  out_channel,
  output logic [7:0]  out_note,
  output logic [7:0]  out_sample,
  output logic [1:0]  out_effect_slot,
  output logic [4:0]  out_effect,
  output logic [7:0]  out_param,
  output logic [5:0]  out_effect_class,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] base_r;
  logic       q_push;
  logic       q_full;
  ppe_evt_t   q_evt;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BASE_CHANNELS) ? {26'd0, base_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= '0;
    else if (psel && penable && pwrite && paddr == REG_BASE_CHANNELS) base_r <= pwdata[5:0];
  end

  ppe_front #(.MAX_TRACKS(MAX_TRACKS), .MAX_EFFECTS(MAX_EFFECTS),
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_data,
    .base_channels(base_r), .q_push, .q_evt, .q_full
  );

  ppe_back u_back (
    .clk, .rst_n, .q_push, .q_evt, .q_full, .out_valid, .out_stall,
    .out_kind, .out_row, .out_channel, .out_note, .out_sample, .out_effect_slot,
    .out_effect, .out_param, .out_effect_class, .out_status
  );

endmodule
